FILE: hdl/sorted_coordinate_table_defines.svh
// Assertion macros shared by the sorted coordinate table checker.
// Depends on nothing; included by the checker file only.
`ifndef SORTED_COORDINATE_TABLE_DEFINES_SVH
`define SORTED_COORDINATE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define SCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sct_pkg.sv
// Shared types, constants and helpers of the sorted coordinate table.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package sct_pkg;

  // Table geometry
  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COORD_W     = 8;
  localparam int TAG_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_ctl_t;

  // True when a sorts strictly before b on (x, y)
  function automatic logic key_less(input entry_t a, input entry_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

FILE: hdl/sorted_coordinate_table.sv
// Sorted coordinate table: holds up to CAPACITY entries of (x, y, tag),
// kept in ascending order by x and then y, with no two entries on one (x, y).
//
// Input channel (in_valid / in_stall): one command word per item, command 0
// inserts (coord_x, coord_y, tag), command 1 removes the first entry whose
// x, y and tag all match. Output channel (out_valid / out_stall): one word
// per command, the status code and the entry count after the command.
// Insert into a full table reports full; a taken position reports duplicate.
//
// Timing: a word is accepted in the idle state, executed in the next state by the
// cell row (all cells compare and shift at once), and then shown on the output
// in the response state. The three-state controller handles one command at
// a time, so no new word is accepted until the result word is taken.
// in_stall stays high from accept until the result word is taken; while the
// receiver stalls, the result word holds steady.
// Reset empties the table at once (count to zero); no clearing pass runs.
// Depends on sct_pkg, sct_ctrl and sct_datapath.
`timescale 1ns / 1ps

module sorted_coordinate_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [sct_pkg::COORD_W-1:0]     coord_x,
  input  logic [sct_pkg::COORD_W-1:0]     coord_y,
  input  logic [sct_pkg::TAG_W-1:0]       tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sct_pkg::STATUS_W-1:0]    status,
  output logic [sct_pkg::COUNT_OUT_W-1:0] entry_count
);

  sct_pkg::dp_ctl_t ctl;

  // Sequencing
  sct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Entry cells and result registers
  sct_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .command     (command),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .tag         (tag),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

FILE: hdl/sct_ctrl.sv
// Controller of the sorted coordinate table: accept, execute, respond.
// Depends on sct_pkg; drives the datapath through sct_pkg::dp_ctl_t.
`timescale 1ns / 1ps

module sct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output sct_pkg::dp_ctl_t ctl
);

  sct_pkg::state_t state;
  sct_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance on input accept, pass through the execute state, hold until the word is taken
  always_comb begin
    state_next = state;
    case (state)
      sct_pkg::S_IDLE: begin
        if (in_valid) state_next = sct_pkg::S_EXEC;
      end
      sct_pkg::S_EXEC: begin
        state_next = sct_pkg::S_RESP;
      end
      sct_pkg::S_RESP: begin
        if (!out_stall) state_next = sct_pkg::S_IDLE;
      end
      default: begin
        state_next = sct_pkg::S_IDLE;
      end
    endcase
  end

  // Drive handshakes and datapath commands
  always_comb begin
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    ctl.capture     = 1'b0;
    ctl.execute     = 1'b0;
    case (state)
      sct_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      sct_pkg::S_EXEC: begin
        ctl.execute = 1'b1;
      end
      sct_pkg::S_RESP: begin
        out_valid   = 1'b1;
      end
      default: begin
        in_stall    = 1'b1;
      end
    endcase
  end

endmodule

FILE: hdl/sct_datapath.sv
// Datapath of the sorted coordinate table: a row of entry cells that all
// compare against the command key and shift at once. Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sct_pkg::dp_ctl_t                ctl,
  input  logic                            command,
  input  logic [sct_pkg::COORD_W-1:0]     coord_x,
  input  logic [sct_pkg::COORD_W-1:0]     coord_y,
  input  logic [sct_pkg::TAG_W-1:0]       tag,
  output logic [sct_pkg::STATUS_W-1:0]    status,
  output logic [sct_pkg::COUNT_OUT_W-1:0] entry_count
);

  localparam logic [sct_pkg::CAPACITY-1:0] ALL_ONES = '1;

  logic                        cmd_q;
  sct_pkg::entry_t             key_q;
  sct_pkg::entry_t             cells      [sct_pkg::CAPACITY];
  sct_pkg::entry_t             cells_next [sct_pkg::CAPACITY];
  logic [sct_pkg::CNT_W-1:0]   count;
  logic [sct_pkg::CNT_W-1:0]   count_next;
  sct_pkg::status_t            status_q;
  sct_pkg::status_t            status_next;

  logic [sct_pkg::CAPACITY-1:0] valid;
  logic [sct_pkg::CAPACITY-1:0] lt;
  logic [sct_pkg::CAPACITY-1:0] dup;
  logic [sct_pkg::CAPACITY-1:0] hit;
  logic [sct_pkg::CAPACITY-1:0] hit_pre;
  logic                         full;

  // Latch the command word on accept
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= command;
      key_q <= '{x: coord_x, y: coord_y, tag: tag};
    end
  end

  // Per-cell compares against the key
  always_comb begin
    for (int i = 0; i < sct_pkg::CAPACITY; i++) begin
      valid[i]   = (sct_pkg::CNT_W'(i) < count);
      lt[i]      = valid[i] && sct_pkg::key_less(cells[i], key_q);
      dup[i]     = valid[i] && (cells[i].x == key_q.x) && (cells[i].y == key_q.y);
      hit[i]     = dup[i] && (cells[i].tag == key_q.tag);
      // Cell i sits at or after the removed entry
      hit_pre[i] = |(hit & (ALL_ONES >> (sct_pkg::CAPACITY - 1 - i)));
    end
  end

  assign full = (count >= sct_pkg::CNT_W'(sct_pkg::CAPACITY));

  // Insert shifts up past the sorted position, remove shifts down over the hit
  always_comb begin
    cells_next  = cells;
    count_next  = count;
    status_next = status_q;
    if (ctl.execute) begin
      if (cmd_q == sct_pkg::CMD_INSERT) begin
        if (full) begin
          status_next = sct_pkg::ST_FULL;
        end else if (|dup) begin
          status_next = sct_pkg::ST_DUPLICATE;
        end else begin
          if (!lt[0]) cells_next[0] = key_q;
          for (int i = 1; i < sct_pkg::CAPACITY; i++) begin
            if (!lt[i]) begin
              cells_next[i] = lt[i-1] ? key_q : cells[i-1];
            end
          end
          count_next  = count + sct_pkg::CNT_W'(1);
          status_next = sct_pkg::ST_INSERTED;
        end
      end else begin
        if (|hit) begin
          for (int i = 0; i < sct_pkg::CAPACITY - 1; i++) begin
            if (hit_pre[i]) cells_next[i] = cells[i+1];
          end
          count_next  = count - sct_pkg::CNT_W'(1);
          status_next = sct_pkg::ST_REMOVED;
        end else begin
          status_next = sct_pkg::ST_NOT_FOUND;
        end
      end
    end
  end

  // Entry cells carry no reset; only cells below the count are ever read
  always_ff @(posedge clk) begin
    for (int i = 0; i < sct_pkg::CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
    status_q <= status_next;
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign status      = status_q;
  assign entry_count = sct_pkg::COUNT_OUT_W'(count);

endmodule

FILE: hdl/sorted_coordinate_table_checker.sv
// Port-level checks of the sorted coordinate table, bound to the top level.
// Depends on sct_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sorted_coordinate_table_defines.svh"

module sorted_coordinate_table_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [sct_pkg::STATUS_W-1:0]    status,
  input logic [sct_pkg::COUNT_OUT_W-1:0] entry_count
);

  // One command in flight: block input right after an accept
  `SCT_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall, "second word accepted while busy")

  // Full status only when the count sits at capacity
  `SCT_ASSERT_NOW(a_full_count, clk, rst, out_valid && (status == sct_pkg::ST_FULL), entry_count == sct_pkg::COUNT_OUT_W'(sct_pkg::CAPACITY), "full reported below capacity")

  // A successful insert leaves a nonempty table
  `SCT_ASSERT_NOW(a_insert_count, clk, rst, out_valid && (status == sct_pkg::ST_INSERTED), entry_count != '0, "insert left an empty table")

  // Hold the result word while stalled
  `SCT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_count), "stalled result changed")

endmodule

bind sorted_coordinate_table sorted_coordinate_table_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .entry_count (entry_count)
);
